### rtl/salru_pkg.sv
package salru_pkg;

  // fixed widths of the ports
  localparam int ADDR_IN_W = 32;
  localparam int WAY_OUT_W = 2;
  localparam int SET_OUT_W = 6;
  localparam int TAG_OUT_W = 21;
  localparam int OFF_OUT_W = 5;
  localparam int CNT_W     = 32;

  // controller to datapath
  typedef struct packed {
    logic clr_step;  // write one cleared set row
    logic load;      // capture address, read its set row
    logic look;      // compare tags of the set row
    logic commit;    // write back set row, load result registers
  } salru_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;  // clear pass is on its last row
  } salru_sts_t;

  // floor of log2 for elaboration-time field sizes
  function automatic int floor_log2(input int v);
    int n;
    int x;
    n = 0;
    x = v;
    for (int i = 0; i < 31; i++) begin
      if (x > 1) begin
        x = x >> 1;
        n = n + 1;
      end
    end
    return n;
  endfunction

endpackage

### rtl/salru_ctrl.sv
module salru_ctrl
  import salru_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  salru_sts_t sts,
  output salru_cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK,
    ST_UPDATE
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_LOOK;
        end
      end
      ST_LOOK: begin
        cmd.look  = 1'b1;
        state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (slot_free) begin
          cmd.commit    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

### rtl/salru_dp.sv
module salru_dp
  import salru_pkg::*;
#(
  parameter int SETS        = 64,
  parameter int WAYS        = 4,
  parameter int BLOCK_BYTES = 32,
  parameter int ADDR_BITS   = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  salru_cmd_t           cmd,
  output salru_sts_t           sts,
  input  logic [ADDR_IN_W-1:0] in_address,
  output logic                 out_hit,
  output logic [WAY_OUT_W-1:0] out_way,
  output logic [SET_OUT_W-1:0] out_set_index,
  output logic [TAG_OUT_W-1:0] out_tag_value,
  output logic [OFF_OUT_W-1:0] out_byte_offset,
  output logic [CNT_W-1:0]     out_access_total,
  output logic [CNT_W-1:0]     out_miss_total
);

  localparam int OFF_BITS = floor_log2(BLOCK_BYTES);
  localparam int SET_BITS = floor_log2(SETS);
  localparam int TS       = OFF_BITS + SET_BITS;
  localparam int TAG_W    = (ADDR_BITS > TS) ? (ADDR_BITS - TS) : 1;
  localparam int IDX_W    = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int ORD_LO   = WAYS;
  localparam int TAG_LO   = WAYS + WAYS * WAY_W;
  localparam int ROW_W    = TAG_LO + WAYS * TAG_W;

  localparam logic [63:0] ADDR_MASK = (ADDR_BITS >= 64) ? '1 :
                                      ((64'd1 << ADDR_BITS) - 64'd1);
  localparam logic [63:0] OFF_MASK  = (64'd1 << OFF_BITS) - 64'd1;
  localparam logic [63:0] SET_MASK  = (64'd1 << SET_BITS) - 64'd1;

  // one row per set: tags, recency order (mru first), valid bits
  logic [ROW_W-1:0]     mem [SETS];
  logic [ROW_W-1:0]     rd_q;
  logic [ROW_W-1:0]     wd;
  logic [IDX_W-1:0]     wa;
  logic                 we;

  logic [IDX_W-1:0]     clr_idx_r;
  logic [ADDR_IN_W-1:0] addr_r;
  logic [WAYS-1:0]      match_r;
  logic [CNT_W-1:0]     acc_r;
  logic [CNT_W-1:0]     miss_r;

  logic [63:0]          in_m;
  logic [IDX_W-1:0]     in_set;
  logic [63:0]          cur_m;
  logic [63:0]          cur_set64;
  logic [63:0]          cur_tag64;
  logic [63:0]          cur_off64;
  logic [IDX_W-1:0]     cur_set;
  logic [TAG_W-1:0]     cur_tag;

  logic [WAYS-1:0]      row_valid;
  logic [WAY_W-1:0]     row_order [WAYS];
  logic [TAG_W-1:0]     row_tag   [WAYS];

  logic                 hit_any;
  logic [WAY_W-1:0]     sel_pos;
  logic [WAY_W-1:0]     sel_way;
  logic [WAYS-1:0]      new_valid;
  logic [ROW_W-1:0]     new_row;
  logic [ROW_W-1:0]     clr_row;

  // set index of the incoming address, for the row read
  always_comb begin
    in_m   = 64'(in_address) & ADDR_MASK;
    in_set = IDX_W'((in_m >> OFF_BITS) & SET_MASK);
  end

  // fields of the address in flight
  always_comb begin
    cur_m     = 64'(addr_r) & ADDR_MASK;
    cur_off64 = cur_m & OFF_MASK;
    cur_set64 = (cur_m >> OFF_BITS) & SET_MASK;
    cur_tag64 = cur_m >> TS;
    cur_set   = cur_set64[IDX_W-1:0];
    cur_tag   = cur_tag64[TAG_W-1:0];
  end

  always_comb begin
    row_valid = rd_q[WAYS-1:0];
    for (int k = 0; k < WAYS; k++) begin
      row_order[k] = rd_q[ORD_LO + k * WAY_W +: WAY_W];
      row_tag[k]   = rd_q[TAG_LO + k * TAG_W +: TAG_W];
    end
  end

  // pick recency position: matching way on hit, else first invalid, else lru
  always_comb begin
    hit_any = |match_r;
    sel_pos = WAY_W'(WAYS - 1);
    for (int p = WAYS - 1; p >= 0; p--) begin
      if (hit_any ? match_r[row_order[p]] : !row_valid[row_order[p]]) begin
        sel_pos = WAY_W'(p);
      end
    end
    sel_way   = row_order[sel_pos];
    new_valid = row_valid | ({WAYS{!hit_any}} & (WAYS'(1) << sel_way));
  end

  always_comb begin
    new_row              = rd_q;
    new_row[WAYS-1:0]    = new_valid;
    new_row[ORD_LO +: WAY_W] = sel_way;
    for (int k = 1; k < WAYS; k++) begin
      if (WAY_W'(k) <= sel_pos) begin
        new_row[ORD_LO + k * WAY_W +: WAY_W] = row_order[k-1];
      end
    end
    for (int k = 0; k < WAYS; k++) begin
      if (!hit_any && (sel_way == WAY_W'(k))) begin
        new_row[TAG_LO + k * TAG_W +: TAG_W] = cur_tag;
      end
    end
  end

  always_comb begin
    clr_row = '0;
    for (int k = 0; k < WAYS; k++) begin
      clr_row[ORD_LO + k * WAY_W +: WAY_W] = WAY_W'(k);
    end
  end

  assign we = cmd.clr_step || cmd.commit;
  assign wa = cmd.clr_step ? clr_idx_r : cur_set;
  assign wd = cmd.clr_step ? clr_row : new_row;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (cmd.load) begin
      rd_q <= mem[in_set];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      addr_r <= in_address;
    end
    if (cmd.look) begin
      for (int k = 0; k < WAYS; k++) begin
        match_r[k] <= row_valid[k] && (row_tag[k] == cur_tag);
      end
    end
    if (cmd.commit) begin
      out_hit         <= hit_any;
      out_way         <= WAY_OUT_W'(sel_way);
      out_set_index   <= cur_set64[SET_OUT_W-1:0];
      out_tag_value   <= cur_tag64[TAG_OUT_W-1:0];
      out_byte_offset <= cur_off64[OFF_OUT_W-1:0];
    end
  end

  // clear pass index and saturating totals
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_idx_r <= '0;
      acc_r     <= '0;
      miss_r    <= '0;
    end else begin
      if (cmd.clr_step) begin
        clr_idx_r <= clr_idx_r + IDX_W'(1);
      end
      if (cmd.commit) begin
        if (acc_r != '1) begin
          acc_r <= acc_r + CNT_W'(1);
        end
        if (!hit_any && (miss_r != '1)) begin
          miss_r <= miss_r + CNT_W'(1);
        end
      end
    end
  end

  assign sts.clr_last     = (clr_idx_r == IDX_W'(SETS - 1));
  assign out_access_total = acc_r;
  assign out_miss_total   = miss_r;

endmodule

### rtl/set_associative_lru_cache.sv
// channel  dir  handshake              payload
// in_      in   in_valid / in_ready    in_address
// out_     out  out_valid / out_ready  out_hit, out_way, out_set_index, out_tag_value,
//                                      out_byte_offset, out_access_total, out_miss_total
//
// one lookup runs set row read, tag compare, then lru/tag write-back
// of the same row; a new lookup is accepted only after the previous one has
// written back, as each is a read-modify-write of one set row in the directory memory
// after reset a clear pass writes every set row, with in_ready low
// a waiting result does not block the next lookup; only the write-back stage
// waits until the result register is free
module set_associative_lru_cache
  import salru_pkg::*;
#(
  parameter int SETS        = 64,
  parameter int WAYS        = 4,
  parameter int BLOCK_BYTES = 32,
  parameter int ADDR_BITS   = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [ADDR_IN_W-1:0] in_address,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_hit,
  output logic [WAY_OUT_W-1:0] out_way,
  output logic [SET_OUT_W-1:0] out_set_index,
  output logic [TAG_OUT_W-1:0] out_tag_value,
  output logic [OFF_OUT_W-1:0] out_byte_offset,
  output logic [CNT_W-1:0]     out_access_total,
  output logic [CNT_W-1:0]     out_miss_total
);

  salru_cmd_t cmd;  // sequencing commands
  salru_sts_t sts;  // clear pass status

  // state machine: clear pass, accept, compare, write-back
  salru_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // directory memory, tag compare, lru update, totals and result registers
  salru_dp #(
    .SETS        (SETS),
    .WAYS        (WAYS),
    .BLOCK_BYTES (BLOCK_BYTES),
    .ADDR_BITS   (ADDR_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_address       (in_address),
    .out_hit          (out_hit),
    .out_way          (out_way),
    .out_set_index    (out_set_index),
    .out_tag_value    (out_tag_value),
    .out_byte_offset  (out_byte_offset),
    .out_access_total (out_access_total),
    .out_miss_total   (out_miss_total)
  );

  // one lookup in flight: ready drops right after an accepted beat
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("lookup accepted while another in flight");

  // misses never outnumber accesses
  a_totals_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_miss_total <= out_access_total))
    else $error("miss total above access total");

  // a fresh result always counts its own access
  a_total_counts: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> (out_access_total != '0))
    else $error("result without counted access");

  // an accepted lookup moves through the compare state to the write-back state, with in_ready still low
  a_commit_timing: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |-> ##2 (!in_ready && ($past(cmd.load, 2))))
    else $error("lookup sequencing broken");

endmodule
